// ===== hdl/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_BACK  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} mode_t;

	typedef struct packed {
		data_t popped;
		logic  error;
		logic  empty;
		logic  full;
		cnt_t  count;
		data_t front;
		data_t back;
	} result_t;

	function automatic idx_t ring_next(input idx_t i);
		ring_next = (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
	endfunction

	function automatic idx_t ring_prev(input idx_t i);
		ring_prev = (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/dq_ram.sv =====
`default_nettype none

module dq_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH_P)-1:0] waddr,
	input  wire logic [WIDTH_P-1:0]         wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH_P)-1:0] raddr,
	output logic      [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/dq_core.sv =====
`default_nettype none

module dq_core
	import dq_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   mode,
	input  wire data_t        push_value,
	output logic              res_valid,
	output result_t           res,
	input  wire logic         res_take
);

	idx_t    head_q, tail_q;
	cnt_t    count_q;
	data_t   front_q, back_q;
	logic    busy_s1, rd_front_s1, rd_back_s1, err_s1;
	data_t   popped_s1;

	mode_t   op;
	logic    accept, is_push, full, empty, err, refill;
	idx_t    head_prev, head_next, tail_next, tail_prev, tail_prev2;
	cnt_t    cnt_dec;
	logic    ram_we, ram_re;
	idx_t    ram_waddr, ram_raddr;
	data_t   ram_rdata;

	assign op         = mode_t'(mode);
	assign in_ready   = !busy_s1;
	assign accept     = in_valid && in_ready;
	assign is_push    = (op == MODE_PUSH_FRONT) || (op == MODE_PUSH_BACK);
	assign full       = (count_q == cnt_t'(DEPTH));
	assign empty      = (count_q == '0);
	assign err        = is_push ? full : empty;
	assign cnt_dec    = count_q - cnt_t'(1);
	// a pop that leaves two or more entries must fetch the new end from memory
	assign refill     = !is_push && !err && (cnt_dec >= cnt_t'(2));

	assign head_prev  = ring_prev(head_q);
	assign head_next  = ring_next(head_q);
	assign tail_next  = ring_next(tail_q);
	assign tail_prev  = ring_prev(tail_q);
	assign tail_prev2 = ring_prev(tail_prev);

	assign ram_we     = accept && is_push && !err;
	assign ram_waddr  = (op == MODE_PUSH_FRONT) ? head_prev : tail_q;
	assign ram_re     = accept && refill;
	assign ram_raddr  = (op == MODE_POP_FRONT) ? head_next : tail_prev2;

	dq_ram #(
		.DEPTH_P(DEPTH),
		.WIDTH_P(DATA_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(push_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			busy_s1     <= 1'b0;
			rd_front_s1 <= 1'b0;
			rd_back_s1  <= 1'b0;
		end else begin
			if (accept) begin
				busy_s1     <= 1'b1;
				rd_front_s1 <= refill && (op == MODE_POP_FRONT);
				rd_back_s1  <= refill && (op == MODE_POP_BACK);
				if (!err) begin
					case (op)
						MODE_PUSH_FRONT: begin
							head_q  <= head_prev;
							count_q <= count_q + cnt_t'(1);
						end
						MODE_PUSH_BACK: begin
							tail_q  <= tail_next;
							count_q <= count_q + cnt_t'(1);
						end
						MODE_POP_FRONT: begin
							head_q  <= head_next;
							count_q <= cnt_dec;
						end
						MODE_POP_BACK: begin
							tail_q  <= tail_prev;
							count_q <= cnt_dec;
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
			end else if (res_take) begin
				busy_s1     <= 1'b0;
				rd_front_s1 <= 1'b0;
				rd_back_s1  <= 1'b0;
			end
		end
	end

	// cached end values; a refill lands when the result leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1    <= err;
			popped_s1 <= '0;
			if (!err) begin
				case (op)
					MODE_PUSH_FRONT: begin
						front_q <= push_value;
						if (empty) begin
							back_q <= push_value;
						end
					end
					MODE_PUSH_BACK: begin
						back_q <= push_value;
						if (empty) begin
							front_q <= push_value;
						end
					end
					MODE_POP_FRONT: begin
						popped_s1 <= front_q;
						if (cnt_dec == cnt_t'(1)) begin
							front_q <= back_q;
						end
					end
					MODE_POP_BACK: begin
						popped_s1 <= back_q;
						if (cnt_dec == cnt_t'(1)) begin
							back_q <= front_q;
						end
					end
					default: begin
						popped_s1 <= '0;
					end
				endcase
			end
		end else if (res_take) begin
			if (rd_front_s1) begin
				front_q <= ram_rdata;
			end
			if (rd_back_s1) begin
				back_q <= ram_rdata;
			end
		end
	end

	assign res_valid  = busy_s1;
	assign res.popped = popped_s1;
	assign res.error  = err_s1;
	assign res.empty  = empty;
	assign res.full   = full;
	assign res.count  = count_q;
	assign res.front  = empty ? '0 : (rd_front_s1 ? ram_rdata : front_q);
	assign res.back   = empty ? '0 : (rd_back_s1 ? ram_rdata : back_q);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("entry count above depth");

	a_err_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err) |=> ($stable(count_q) && $stable(head_q) && $stable(tail_q)))
		else $error("rejected word changed queue state");

	a_refill_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_front_s1 || rd_back_s1) |-> (busy_s1 && count_q >= cnt_t'(2)))
		else $error("refill pending without two entries");

	a_one_refill: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_front_s1 && rd_back_s1))
		else $error("both ends refilled at once");
`endif

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
`default_nettype none

// Bounded double-ended queue of DEPTH unsigned words held in a ring buffer
// memory. Each input word carries an operation in mode (push front, push
// back, pop front, pop back) and the value to push; each one yields exactly
// one result word with the popped value, an error flag, the empty and full
// flags, the entry count and the front and back entries as they stand after
// the operation (zero when empty). A pop on an empty queue or a push on a
// full queue raises error and leaves the queue untouched. On acceptance
// the core updates the ring pointers and writes or reads the slot memory;
// it then catches the registered memory read that refills the front or
// back cache after a pop and hands the result to the output register once
// that register is free or draining. No new word is accepted until then.
// While the output register waits on out_ready, one further word can be
// accepted and held in the core.
module double_ended_queue
	import dq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        mode,
	input  wire logic [DATA_W-1:0] push_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [DATA_W-1:0]      popped_value,
	output logic                   error,
	output logic                   is_empty,
	output logic                   is_full,
	output logic [CNT_W-1:0]       entry_count,
	output logic [DATA_W-1:0]      front_value,
	output logic [DATA_W-1:0]      back_value
);

	logic    res_valid, res_take, out_valid_q;
	result_t res, out_q;

	dq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.push_value(push_value),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// move the result out whenever the output register is free or draining
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload until the word is taken
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = out_q.popped;
	assign error        = out_q.error;
	assign is_empty     = out_q.empty;
	assign is_full      = out_q.full;
	assign entry_count  = out_q.count;
	assign front_value  = out_q.front;
	assign back_value   = out_q.back;

endmodule

`default_nettype wire
